@@ rtl/pss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority sleep task scheduler package
// Sizes, operation codes and the types shared by the scheduler cells and the
// top level.
// ----------------------------------------------------------------------------
package pss_pkg;

   localparam int MAX_TASKS  = 16;
   localparam int TIME_WIDTH = 32;

   localparam int IDX_W   = $clog2(MAX_TASKS);
   localparam int CNT_W   = $clog2(MAX_TASKS + 1);
   localparam int PRIO_W  = 8;
   localparam int FUNC_W  = 2;
   localparam int SLEEP_W = 32;
   localparam int ID_W    = 4;
   localparam int CTIME_W = 32;

   localparam int REQ_BITS = FUNC_W + PRIO_W + SLEEP_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = ID_W + 1 + ID_W + 1 + CTIME_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [FUNC_W-1:0] FUNC_REGISTER = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SLEEP    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd2;

   // Selection token that walks down the row of cells.
   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  idx;
      logic [PRIO_W-1:0] prio;
   } tok_type;

   // Commands broadcast from the sequencer to every cell.
   typedef struct packed {
      logic                  reg_we;
      logic                  adj_en;
      logic                  sleep;
      logic [IDX_W-1:0]      act;
      logic [CNT_W-1:0]      count;
      logic [PRIO_W-1:0]     prio;
      logic [TIME_WIDTH-1:0] now;
      logic [TIME_WIDTH-1:0] now_inc;
      logic [TIME_WIDTH-1:0] wake_sum;
   } cell_ctl_type;

endpackage

@@ rtl/pss_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler task cell
// Holds the priority and wake time of one task slot and updates the passing
// selection token when this task is ready and outranks the candidate.
// ----------------------------------------------------------------------------
module pss_cell
   import pss_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [IDX_W-1:0]  cell_idx,
   input  cell_ctl_type      ctl,
   input  tok_type           tok_i,
   output tok_type           tok_o,
   output logic [PRIO_W-1:0] prio_o
);

   logic [PRIO_W-1:0]     prio_ff;
   logic [TIME_WIDTH-1:0] wake_ff;
   logic [TIME_WIDTH-1:0] wake_in;
   logic [TIME_WIDTH-1:0] wake_new;
   tok_type               tok_ff;
   tok_type               tok_in;
   logic                  used;
   logic                  take;
   logic                  is_slot;
   logic                  is_act;

   assign used    = CNT_W'(cell_idx) < ctl.count;
   assign is_slot = ctl.reg_we && (CNT_W'(cell_idx) == ctl.count);
   assign is_act  = ctl.adj_en && (cell_idx == ctl.act);

   // A wake time that has fallen behind now is pushed to the next tick.
   assign wake_new = ctl.sleep ? ctl.wake_sum : wake_ff;

   always_comb begin
      wake_in = wake_ff;
      if (is_slot) begin
         wake_in = '0;
      end else if (is_act) begin
         wake_in = (wake_new < ctl.now) ? ctl.now_inc : wake_new;
      end
   end

   assign take = tok_i.valid && used && (wake_ff <= ctl.now) && (prio_ff > tok_i.prio);

   always_comb begin
      tok_in = tok_i;
      if (take) begin
         tok_in.idx  = cell_idx;
         tok_in.prio = prio_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      wake_ff <= wake_in;
      if (is_slot) begin
         prio_ff <= ctl.prio;
      end
   end

   assign tok_o  = tok_ff;
   assign prio_o = prio_ff;

endmodule

@@ rtl/priority_sleep_task_scheduler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority sleep task scheduler
// Task table held in a row of cells, with a sequencer for register, sleep and
// tick items.
// ----------------------------------------------------------------------------
// A register item, an unused code, or a sleep or tick with no tasks goes from
// decode straight to the finish state. For a sleep or tick, after the wake
// time update, a selection token walks through the row of task cells one cell
// per cycle, each cell holding one task, and the last cell hands back the
// chosen task. One item is worked on at a time; the next item is accepted in
// the cycle in which the result is first offered. The result sits in an
// output register while the next item is accepted.
module priority_sleep_task_scheduler_top
   import pss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // func [1:0], priority_req [9:2], sleep_time [41:10], zeros above
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // active_task [3:0], switched [4], task_id [8:5], table_full [9],
   // current_time [41:10], zeros above
   output logic [RSP_W-1:0] rsp_tdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ADJUST,
      ST_SEED,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type             state_ff;
   logic [FUNC_W-1:0]     func_ff;
   logic [PRIO_W-1:0]     prio_ff;
   logic [SLEEP_W-1:0]    slp_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [IDX_W-1:0]      running_ff;
   logic [IDX_W-1:0]      before_ff;
   logic [IDX_W-1:0]      act_ff;
   logic [IDX_W-1:0]      new_id_ff;
   logic                  full_ff;
   logic [TIME_WIDTH-1:0] tick_ff;
   logic [TIME_WIDTH-1:0] sum_ff;
   logic                  rsp_tvalid_ff;
   logic [RSP_W-1:0]      rsp_tdata_ff;

   cell_ctl_type          ctl;
   tok_type               chain [MAX_TASKS+1];
   logic [PRIO_W-1:0]     prio_vec [MAX_TASKS];
   logic [IDX_W-1:0]      seed_idx;
   logic                  has_room;
   logic                  accept;
   logic                  out_free;
   logic [RSP_W-1:0]      rsp_in;

   assign accept   = req_tvalid && req_tready;
   assign has_room = count_ff < CNT_W'(MAX_TASKS);
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   assign ctl.reg_we   = (state_ff == ST_DECODE) && (func_ff == FUNC_REGISTER) && has_room;
   assign ctl.adj_en   = (state_ff == ST_ADJUST);
   assign ctl.sleep    = (func_ff == FUNC_SLEEP);
   assign ctl.act      = act_ff;
   assign ctl.count    = count_ff;
   assign ctl.prio     = prio_ff;
   assign ctl.now      = tick_ff;
   assign ctl.now_inc  = tick_ff + TIME_WIDTH'(1);
   assign ctl.wake_sum = sum_ff;

   // Sleep restarts the search from task 0, tick from the running task.
   assign seed_idx        = ctl.sleep ? '0 : act_ff;
   assign chain[0].valid  = (state_ff == ST_SEED);
   assign chain[0].idx    = seed_idx;
   assign chain[0].prio   = prio_vec[seed_idx];

   for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
      pss_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(g)),
         .ctl      (ctl),
         .tok_i    (chain[g]),
         .tok_o    (chain[g+1]),
         .prio_o   (prio_vec[g])
      );
   end

   assign rsp_in = {(RSP_W - RSP_BITS)'(0), CTIME_W'(tick_ff), full_ff, ID_W'(new_id_ff),
                    running_ff != before_ff, ID_W'(running_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         running_ff    <= '0;
         tick_ff       <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  func_ff   <= req_tdata[FUNC_W-1:0];
                  prio_ff   <= req_tdata[FUNC_W +: PRIO_W];
                  slp_ff    <= req_tdata[FUNC_W+PRIO_W +: SLEEP_W];
                  before_ff <= running_ff;
                  new_id_ff <= '0;
                  full_ff   <= 1'b0;
                  state_ff  <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               state_ff <= ST_FINISH;
               case (func_ff)
                  FUNC_REGISTER: begin
                     if (has_room) begin
                        new_id_ff <= count_ff[IDX_W-1:0];
                        count_ff  <= count_ff + CNT_W'(1);
                     end else begin
                        full_ff <= 1'b1;
                     end
                  end
                  FUNC_SLEEP, FUNC_TICK: begin
                     if (count_ff == '0) begin
                        full_ff <= 1'b1;
                     end else begin
                        act_ff   <= (CNT_W'(running_ff) < count_ff) ? running_ff : '0;
                        sum_ff   <= tick_ff + TIME_WIDTH'(slp_ff);
                        state_ff <= ST_ADJUST;
                        if (func_ff == FUNC_TICK) begin
                           tick_ff <= tick_ff + TIME_WIDTH'(1);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            ST_ADJUST: begin
               state_ff <= ST_SEED;
            end
            ST_SEED: begin
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (chain[MAX_TASKS].valid) begin
                  running_ff <= chain[MAX_TASKS].idx;
                  state_ff   <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if ((state_ff == ST_FINISH) && out_free) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_tdata_ff <= rsp_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

@@ rtl/pss_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler port checker
// Watches the ports for result items the scheduler can never produce, results
// changed while stalled, a valid result after reset, ready after an accept.
// ----------------------------------------------------------------------------
module pss_port_checker
   import pss_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // A stalled result item must stay put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // A result never reports a switch together with an empty or full table.
   a_full_no_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[9] && rsp_tdata[4]))
      else $error("switch reported on a rejected item");

   // A freshly registered task id only comes with a register item.
   a_id_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[8:5] != 4'd0) |-> !rsp_tdata[4] && !rsp_tdata[9])
      else $error("task id given on an item that was not a register");

   // The result register is empty straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // The scheduler is never ready again straight after it has taken an item.
   a_accept_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("scheduler ready again straight after accepting an item");

endmodule

bind priority_sleep_task_scheduler_top pss_port_checker u_pss_port_checker (.*);
